// ===== rtl/erie_pkg.sv =====
// Package: shared item/result types, op and instruction codes, access width helper.
`timescale 1ns / 1ps

package erie_pkg;

  // op codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // instruction codes
  localparam logic [7:0] INS_READ      = 8'h00;
  localparam logic [7:0] INS_READ_CMP  = 8'h01;
  localparam logic [7:0] INS_WRITE     = 8'h02;
  localparam logic [7:0] INS_WRITE_IMM = 8'h03;
  localparam logic [7:0] INS_NOP       = 8'h04;
  localparam logic [7:0] INS_LOAD_ONE  = 8'h05;
  localparam logic [7:0] INS_LOAD_TWO  = 8'h06;
  localparam logic [7:0] INS_STORE_ONE = 8'h07;
  localparam logic [7:0] INS_ADD_VAR   = 8'h08;
  localparam logic [7:0] INS_SUB_VAR   = 8'h09;
  localparam logic [7:0] INS_ADD_VAL   = 8'h0A;
  localparam logic [7:0] INS_SUB_VAL   = 8'h0B;
  localparam logic [7:0] INS_DELAY     = 8'h0C;
  localparam logic [7:0] INS_SET_SRC   = 8'h10;
  localparam logic [7:0] INS_SET_DST   = 8'h11;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  action;
    logic [7:0]  instruction;
    logic        preserve;
    logic [5:0]  fld_shift;
    logic [7:0]  reg_bits;
    logic        space_is_io;
    logic [63:0] reg_address;
    logic [63:0] data_value;
    logic [63:0] mask;
    logic [63:0] read_data;
    logic        optional;
  } item_t;

  typedef struct packed {
    logic        write_enable;
    logic [63:0] write_address;
    logic        write_is_io;
    logic [63:0] write_data;
    logic [63:0] stall_count;
    logic        action_done;
    logic [63:0] action_value;
    logic        action_ok;
  } result_t;

  // I/O space tops out at 32 bits
  function automatic logic [63:0] width_mask(logic [7:0] bw, logic io);
    logic [63:0] m;
    begin
      if (bw == 8'd8) m = 64'h0000_0000_0000_00FF;
      else if (bw == 8'd16) m = 64'h0000_0000_0000_FFFF;
      else if (bw == 8'd64 && !io) m = '1;
      else m = 64'h0000_0000_FFFF_FFFF;
      return m;
    end
  endfunction

endpackage

// ===== rtl/erie_exec.sv =====
// Entry execution: action state registers and the combinational entry logic.
`timescale 1ns / 1ps

module erie_exec (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  erie_pkg::item_t item_i,
  input  logic            fire_i,
  output erie_pkg::result_t res_o
);
  import erie_pkg::*;

  logic [7:0]  cur_action_q, cur_action_d;
  logic [63:0] run_q, run_d;
  logic [63:0] scr_one_q, scr_one_d;
  logic [63:0] scr_two_q, scr_two_d;
  logic        found_q, found_d;
  logic        failed_q, failed_d;

  logic [63:0] wm, rd, field, fmask, wv, wsrc;
  logic        wr;

  always_comb begin
    wm    = width_mask(item_i.reg_bits, item_i.space_is_io);
    rd    = item_i.read_data & wm;
    field = (rd >> item_i.fld_shift) & item_i.mask;
    fmask = item_i.mask << item_i.fld_shift;
    wsrc  = (item_i.instruction == INS_WRITE_IMM) ? item_i.data_value : run_q;

    cur_action_d = cur_action_q;
    run_d        = run_q;
    scr_one_d    = scr_one_q;
    scr_two_d    = scr_two_q;
    found_d      = found_q;
    failed_d     = failed_q;
    wr           = 1'b0;
    wv           = '0;
    res_o        = '0;

    if (item_i.op == OP_BEGIN) begin
      cur_action_d = item_i.action;
      run_d        = item_i.data_value;
      scr_one_d    = '0;
      scr_two_d    = '0;
      found_d      = 1'b0;
      failed_d     = 1'b0;
    end else if (item_i.op == OP_END) begin
      res_o.action_done  = 1'b1;
      res_o.action_value = run_q;
      res_o.action_ok    = !failed_q && (found_q || item_i.optional);
    end else if (item_i.op == OP_EXEC && !failed_q && item_i.action == cur_action_q) begin
      found_d = 1'b1;
      case (item_i.instruction) inside
        INS_READ:     run_d = field;
        INS_READ_CMP: run_d = {63'd0, field == item_i.data_value};
        INS_WRITE, INS_WRITE_IMM: begin
          wv = (wsrc & item_i.mask) << item_i.fld_shift;
          if (item_i.preserve) wv = wv | (rd & ~fmask);
          wr = 1'b1;
        end
        INS_LOAD_ONE: scr_one_d = field;
        INS_LOAD_TWO: scr_two_d = field;
        INS_STORE_ONE: begin
          wv = (scr_one_q & item_i.mask) << item_i.fld_shift;
          wr = 1'b1;
        end
        INS_ADD_VAR: scr_one_d = scr_one_q + scr_two_q;
        INS_SUB_VAR: scr_one_d = scr_one_q - scr_two_q;
        INS_ADD_VAL: run_d = run_q + item_i.data_value;
        INS_SUB_VAL: run_d = run_q - item_i.data_value;
        // x100 = x64 + x32 + x4
        INS_DELAY: res_o.stall_count = (item_i.data_value << 6) +
                                       (item_i.data_value << 5) +
                                       (item_i.data_value << 2);
        INS_NOP, INS_SET_SRC, INS_SET_DST: ;
        default: failed_d = 1'b1;
      endcase
      if (wr) begin
        res_o.write_enable  = 1'b1;
        res_o.write_address = item_i.reg_address;
        res_o.write_is_io   = item_i.space_is_io;
        res_o.write_data    = wv & wm;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_action_q <= '0;
      run_q        <= '0;
      scr_one_q    <= '0;
      scr_two_q    <= '0;
      found_q      <= 1'b0;
      failed_q     <= 1'b0;
    end else if (fire_i) begin
      cur_action_q <= cur_action_d;
      run_q        <= run_d;
      scr_one_q    <= scr_one_d;
      scr_two_q    <= scr_two_d;
      found_q      <= found_d;
      failed_q     <= failed_d;
    end
  end

endmodule

// ===== rtl/error_record_instruction_executor.sv =====
// Error-record serialization instruction executor: top level with input and result registers.
//
// One serialization table entry per input transaction (valid_i / stall_o), one result
// transaction per entry (valid_o / stall_i). A begin transaction latches the action and
// its input value, execute transactions apply one table entry each, and an end
// transaction reports the running value and the pass/fail status.
// A transaction accepted into the input register passes through the entry logic into
// the result register (two register stages: input register, then result register).
// Throughput: one transaction per cycle while the receiver does not stall; each entry is a
// single shift/mask/add on the registered item, done in the entry logic between the two registers.
// Reset clears the action state (latched action, running value, both scratch values,
// found and failure flags) and empties both stages.
// When the receiver stalls, the result register holds; the input register still takes
// one more transaction, and stall_o rises only once both stages are full.
`timescale 1ns / 1ps

module error_record_instruction_executor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  action_i,
  input  logic [7:0]  instruction_i,
  input  logic        preserve_i,
  input  logic [5:0]  fld_shift_i,
  input  logic [7:0]  reg_bits_i,
  input  logic        space_is_io_i,
  input  logic [63:0] reg_address_i,
  input  logic [63:0] data_value_i,
  input  logic [63:0] mask_i,
  input  logic [63:0] read_data_i,
  input  logic        optional_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        write_enable_o,
  output logic [63:0] write_address_o,
  output logic        write_is_io_o,
  output logic [63:0] write_data_o,
  output logic [63:0] stall_count_o,
  output logic        action_done_o,
  output logic [63:0] action_value_o,
  output logic        action_ok_o
);
  import erie_pkg::*;

  item_t   item_q;
  logic    in_vld_q;
  result_t res_d, res_q;
  logic    out_vld_q;
  logic    out_ready, fire;

  assign out_ready = !out_vld_q || !stall_i;
  assign fire      = in_vld_q && out_ready;
  assign stall_o   = in_vld_q && !out_ready;

  erie_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_q),
    .fire_i (fire),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!stall_o) in_vld_q <= valid_i;
      if (out_ready) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q <= '{op: op_i, action: action_i, instruction: instruction_i,
                  preserve: preserve_i, fld_shift: fld_shift_i,
                  reg_bits: reg_bits_i, space_is_io: space_is_io_i,
                  reg_address: reg_address_i, data_value: data_value_i,
                  mask: mask_i, read_data: read_data_i, optional: optional_i};
    end
    if (fire) res_q <= res_d;
  end

  assign valid_o         = out_vld_q;
  assign write_enable_o  = res_q.write_enable;
  assign write_address_o = res_q.write_address;
  assign write_is_io_o   = res_q.write_is_io;
  assign write_data_o    = res_q.write_data;
  assign stall_count_o   = res_q.stall_count;
  assign action_done_o   = res_q.action_done;
  assign action_value_o  = res_q.action_value;
  assign action_ok_o     = res_q.action_ok;

endmodule

// ===== test/tb_error_record_instruction_executor.sv =====
// Testbench for the error-record serialization instruction executor: directed and random entries.
`timescale 1ns / 1ps

module tb_error_record_instruction_executor;
  import erie_pkg::*;

  // stimulus-only codes: an op the block does not define and an unlisted instruction
  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [7:0] INS_UNKNOWN = 8'hFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  op_i = OP_BEGIN;
  logic [7:0]  action_i = '0;
  logic [7:0]  instruction_i = INS_READ;
  logic        preserve_i = 1'b0;
  logic [5:0]  fld_shift_i = '0;
  logic [7:0]  reg_bits_i = '0;
  logic        space_is_io_i = 1'b0;
  logic [63:0] reg_address_i = '0;
  logic [63:0] data_value_i = '0;
  logic [63:0] mask_i = '0;
  logic [63:0] read_data_i = '0;
  logic        optional_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        write_enable_o;
  logic [63:0] write_address_o;
  logic        write_is_io_o;
  logic [63:0] write_data_o;
  logic [63:0] stall_count_o;
  logic        action_done_o;
  logic [63:0] action_value_o;
  logic        action_ok_o;

  error_record_instruction_executor u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .op_i            (op_i),
    .action_i        (action_i),
    .instruction_i   (instruction_i),
    .preserve_i      (preserve_i),
    .fld_shift_i     (fld_shift_i),
    .reg_bits_i      (reg_bits_i),
    .space_is_io_i   (space_is_io_i),
    .reg_address_i   (reg_address_i),
    .data_value_i    (data_value_i),
    .mask_i          (mask_i),
    .read_data_i     (read_data_i),
    .optional_i      (optional_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .write_enable_o  (write_enable_o),
    .write_address_o (write_address_o),
    .write_is_io_o   (write_is_io_o),
    .write_data_o    (write_data_o),
    .stall_count_o   (stall_count_o),
    .action_done_o   (action_done_o),
    .action_value_o  (action_value_o),
    .action_ok_o     (action_ok_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // 0: sender 36% / receiver 72% idle, 1: the other way round, 2: no idling
  int traffic_mode = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  result_t pending_results[$];

  // executor state as predicted
  logic [7:0]  latched_action = '0;
  logic [63:0] run_value = '0;
  logic [63:0] scratch_a = '0;
  logic [63:0] scratch_b = '0;
  logic        found_flag = 1'b0;
  logic        fail_flag = 1'b0;

  function automatic int sender_idle_pct();
    case (traffic_mode)
      0: return 36;
      1: return 72;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (traffic_mode)
      0: return 72;
      1: return 36;
      default: return 0;
    endcase
  endfunction

  // I/O accesses never exceed 32 bits
  function automatic logic [63:0] access_mask(logic [7:0] bw, logic io);
    if (bw == 8'd8) return 64'hFF;
    if (bw == 8'd16) return 64'hFFFF;
    if (bw == 8'd64 && !io) return '1;
    return 64'hFFFF_FFFF;
  endfunction

  function automatic result_t predict_entry(item_t it);
    result_t     r;
    logic [63:0] wmask;
    logic [63:0] rd;
    logic [63:0] field;
    logic [63:0] wv;
    logic        wr;
    r = '0;
    wmask = access_mask(it.reg_bits, it.space_is_io);
    rd = it.read_data & wmask;
    field = (rd >> it.fld_shift) & it.mask;
    wr = 1'b0;
    wv = '0;
    case (it.op)
      OP_BEGIN: begin
        latched_action = it.action;
        run_value = it.data_value;
        scratch_a = '0;
        scratch_b = '0;
        found_flag = 1'b0;
        fail_flag = 1'b0;
      end
      OP_END: begin
        r.action_done = 1'b1;
        r.action_value = run_value;
        r.action_ok = !fail_flag && (found_flag || it.optional);
      end
      OP_EXEC: begin
        if (!fail_flag && it.action == latched_action) begin
          found_flag = 1'b1;
          case (it.instruction)
            INS_READ:     run_value = field;
            INS_READ_CMP: run_value = (field == it.data_value) ? 64'd1 : 64'd0;
            INS_WRITE, INS_WRITE_IMM: begin
              wv = ((it.instruction == INS_WRITE_IMM ? it.data_value : run_value) & it.mask)
                   << it.fld_shift;
              if (it.preserve) wv |= rd & ~(it.mask << it.fld_shift);
              wr = 1'b1;
            end
            INS_NOP, INS_SET_SRC, INS_SET_DST: ;
            INS_LOAD_ONE: scratch_a = field;
            INS_LOAD_TWO: scratch_b = field;
            INS_STORE_ONE: begin
              wv = (scratch_a & it.mask) << it.fld_shift;
              wr = 1'b1;
            end
            INS_ADD_VAR: scratch_a = scratch_a + scratch_b;
            INS_SUB_VAR: scratch_a = scratch_a - scratch_b;
            INS_ADD_VAL: run_value = run_value + it.data_value;
            INS_SUB_VAL: run_value = run_value - it.data_value;
            INS_DELAY:   r.stall_count = it.data_value * 64'd100;
            default:     fail_flag = 1'b1;
          endcase
          if (wr) begin
            r.write_enable = 1'b1;
            r.write_address = it.reg_address;
            r.write_is_io = it.space_is_io;
            r.write_data = wv & wmask;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 255));
      3: return (64'd1 << $urandom_range(1, 63)) - 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] known_code(int k);
    case (k)
      0: return INS_READ;
      1: return INS_READ_CMP;
      2: return INS_WRITE;
      3: return INS_WRITE_IMM;
      4: return INS_NOP;
      5: return INS_LOAD_ONE;
      6: return INS_LOAD_TWO;
      7: return INS_STORE_ONE;
      8: return INS_ADD_VAR;
      9: return INS_SUB_VAR;
      10: return INS_ADD_VAL;
      11: return INS_SUB_VAL;
      12: return INS_DELAY;
      13: return INS_SET_SRC;
      default: return INS_SET_DST;
    endcase
  endfunction

  function automatic logic [7:0] pick_instruction();
    if ($urandom_range(0, 39) == 0) return 8'($urandom);
    return known_code($urandom_range(0, 14));
  endfunction

  // a few codes most of the time so begin and entries line up
  function automatic logic [7:0] pick_action();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 3));
  endfunction

  function automatic item_t make_entry(logic [1:0] op, logic [7:0] act, logic [7:0] ins);
    item_t it;
    it.op = op;
    it.action = act;
    it.instruction = ins;
    it.preserve = 1'($urandom_range(0, 1));
    it.fld_shift = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
    case ($urandom_range(0, 4))
      0: it.reg_bits = 8'd8;
      1: it.reg_bits = 8'd16;
      2: it.reg_bits = 8'd32;
      3: it.reg_bits = 8'd64;
      default: it.reg_bits = 8'($urandom);
    endcase
    it.space_is_io = 1'($urandom_range(0, 1));
    it.reg_address = rand_word();
    it.data_value = rand_word();
    it.mask = rand_word();
    it.read_data = rand_word();
    it.optional = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    op_i <= it.op;
    action_i <= it.action;
    instruction_i <= it.instruction;
    preserve_i <= it.preserve;
    fld_shift_i <= it.fld_shift;
    reg_bits_i <= it.reg_bits;
    space_is_io_i <= it.space_is_io;
    reg_address_i <= it.reg_address;
    data_value_i <= it.data_value;
    mask_i <= it.mask;
    read_data_i <= it.read_data;
    optional_i <= it.optional;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    pending_results.push_back(predict_entry(it));
  endtask

  // receiver side: random stall, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_served != hold_reqs) begin
      hold_served = hold_reqs;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transaction with nothing expected", $time);
      end else begin
        want = pending_results.pop_front();
        compare_field("write_enable", 64'(want.write_enable), 64'(write_enable_o));
        compare_field("write_address", want.write_address, write_address_o);
        compare_field("write_is_io", 64'(want.write_is_io), 64'(write_is_io_o));
        compare_field("write_data", want.write_data, write_data_o);
        compare_field("stall_count", want.stall_count, stall_count_o);
        compare_field("action_done", 64'(want.action_done), 64'(action_done_o));
        compare_field("action_value", want.action_value, action_value_o);
        compare_field("action_ok", 64'(want.action_ok), 64'(action_ok_o));
      end
    end
  end

  // entries ahead of any begin run against the reset state (action zero)
  task automatic test_before_begin();
    item_t it;
    it = make_entry(OP_EXEC, 8'h00, INS_ADD_VAL);
    it.data_value = '1;
    send_item(it);
    send_item(make_entry(OP_NONE, 8'hFF, INS_UNKNOWN));
    it = make_entry(OP_END, 8'h00, INS_READ);
    it.optional = 1'b0;
    send_item(it);
  endtask

  task automatic test_each_instruction();
    item_t it;
    it = make_entry(OP_BEGIN, 8'hFF, INS_READ);
    it.data_value = '1;
    send_item(it);
    for (int k = 0; k < 15; k++) begin
      it = make_entry(OP_EXEC, 8'hFF, known_code(k));
      it.fld_shift = (k % 3 == 0) ? 6'd63 : ((k % 3 == 1) ? 6'd0 : it.fld_shift);
      it.preserve = k[0];
      send_item(it);
    end
    send_item(make_entry(OP_END, 8'hFF, INS_READ));
  endtask

  task automatic test_failure_and_mismatch();
    item_t it;
    send_item(make_entry(OP_BEGIN, 8'h5A, INS_READ));
    send_item(make_entry(OP_EXEC, 8'hA5, INS_ADD_VAL));
    it = make_entry(OP_END, 8'h5A, INS_READ);
    it.optional = 1'b0;
    send_item(it);
    it.optional = 1'b1;
    send_item(it);
    send_item(make_entry(OP_EXEC, 8'h5A, INS_UNKNOWN));
    send_item(make_entry(OP_EXEC, 8'h5A, INS_WRITE_IMM));
    send_item(it);
  endtask

  task automatic test_random_traffic(input int mode, input int target);
    int          sent;
    int          n;
    logic [7:0]  act;
    item_t       it;
    traffic_mode = mode;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        act = pick_action();
        send_item(make_entry(OP_BEGIN, act, INS_READ));
        n = $urandom_range(1, 12);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0)
            send_item(make_entry(OP_EXEC, pick_action(), pick_instruction()));
          else
            send_item(make_entry(OP_EXEC, act, pick_instruction()));
        end
        send_item(make_entry(OP_END, act, INS_READ));
        sent += n + 2;
      end else begin
        it = make_entry(2'($urandom_range(0, 3)), pick_action(), 8'($urandom));
        send_item(it);
        if (it.op inside {OP_BEGIN, OP_EXEC, OP_END}) sent++;
      end
    end
  endtask

  // long receiver hold-off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    traffic_mode = 2;
    hold_reqs++;
    send_item(make_entry(OP_BEGIN, 8'h01, INS_READ));
    repeat (20) send_item(make_entry(OP_EXEC, 8'h01, pick_instruction()));
    send_item(make_entry(OP_END, 8'h01, INS_READ));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_begin();
    test_each_instruction();
    test_failure_and_mismatch();
    test_random_traffic(0, 400);
    test_backpressure();
    test_random_traffic(1, 400);
    test_random_traffic(2, 300);
    valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
